// ===== rtl/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// tss_pkg: shared types, constants and trig tables
// Widths, register codes, particle word layout and the Q1.15 axis tables for
// the transverse spherocity angle scan.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int MAX_PARTICLES = 1024;
  localparam int ANGLE_STEPS   = 360;
  localparam int CLASSES       = 4;
  localparam int NKIND         = 2;

  localparam int COORD_W  = 16;
  localparam int COORD_EW = COORD_W + 1;
  localparam int PT_W     = 16;
  localparam int MASK_W   = 4;
  localparam int CLASS_W  = 2;
  localparam int RES_W    = 16;
  localparam int ADDR_W   = $clog2(MAX_PARTICLES);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int ANG_W    = $clog2(ANGLE_STEPS);
  localparam int SEL_W    = $clog2(NKIND * CLASSES);
  localparam int DEN_W    = 26;
  localparam int NUM_W    = DEN_W + RES_W;
  localparam int MUL_W    = 33;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int CROSS_W  = 34;
  localparam int SQ_W     = 32;
  localparam int STEP_W   = 3;
  localparam int DBIT_W   = $clog2(RES_W);
  localparam int UNIT_SHIFT = 15;
  localparam int CNT_SHIFT  = 14;
  localparam int SCALE_SHIFT = 46;

  localparam logic [MUL_W-1:0] QUARTER_PI_SQ = 33'd2649351758;

  localparam logic [63:0] K1 = 64'd1686629713;
  localparam logic [63:0] K3 = 64'd693598668;
  localparam logic [63:0] K5 = 64'd85569306;
  localparam logic [63:0] K7 = 64'd5026995;
  localparam logic [63:0] K9 = 64'd172272;
  localparam logic [63:0] FRAC30 = 64'h3FFF_FFFF;
  localparam logic [63:0] ONE30  = 64'h4000_0000;

  // configuration register codes
  typedef enum logic [0:0] {
    REG_EN_PT   = 1'b0,
    REG_EN_UNIT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [PT_W-1:0]           t;
    logic [MASK_W-1:0]         mask;
  } particle_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ux;
    logic signed [COORD_W-1:0] uy;
  } unit_vec_t;

  typedef logic signed [COORD_W-1:0] trig_tab_t [ANGLE_STEPS];

  // sin(pi/2 * x), x in Q0.30, odd Taylor polynomial, result Q1.15
  function automatic logic [COORD_W-1:0] quarter_sine(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] r;
    x2 = (x * x) >> 30;
    t  = K9;
    t  = K7 - ((x2 * t) >> 30);
    t  = K5 - ((x2 * t) >> 30);
    t  = K3 - ((x2 * t) >> 30);
    t  = K1 - ((x2 * t) >> 30);
    r  = (((x * t) >> 30) + 64'd16384) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return r[COORD_W-1:0];
  endfunction

  // build the cosine (want_sin = 0) or sine table over the full circle
  function automatic trig_tab_t build_trig(input logic want_sin);
    trig_tab_t   tab;
    logic [63:0] ph;
    logic [63:0] f;
    logic [1:0]  quad;
    logic [COORD_W-1:0] s;
    logic [COORD_W-1:0] c;
    logic [COORD_W-1:0] sv;
    logic [COORD_W-1:0] cv;
    for (int k = 0; k < ANGLE_STEPS; k++) begin
      ph   = {32'(k), 32'h0} / ANGLE_STEPS;
      quad = ph[31:30];
      f    = ph & FRAC30;
      s    = quarter_sine(f);
      c    = quarter_sine(ONE30 - f);
      unique case (quad)
        2'd0: begin sv = s;         cv = c;         end
        2'd1: begin sv = c;         cv = ~s + 1'b1; end
        2'd2: begin sv = ~s + 1'b1; cv = ~c + 1'b1; end
        default: begin sv = ~c + 1'b1; cv = s; end
      endcase
      tab[k] = want_sin ? signed'(sv) : signed'(cv);
    end
    return tab;
  endfunction

  localparam trig_tab_t COS_TAB = build_trig(1'b0);
  localparam trig_tab_t SIN_TAB = build_trig(1'b1);

  // |p| << 15 as a dividend for the unit vector
  function automatic logic [NUM_W-1:0] unit_num(input logic signed [COORD_W-1:0] p);
    logic signed [COORD_EW-1:0] e;
    logic [COORD_EW-1:0]        m;
    e = COORD_EW'(p);
    m = e[COORD_EW-1] ? unsigned'(-e) : unsigned'(e);
    return NUM_W'(m) << UNIT_SHIFT;
  endfunction

  // signed unit component from magnitude quotient, clamped to 16 bits
  function automatic logic signed [COORD_W-1:0] unit_clamp(input logic neg,
                                                           input logic sat,
                                                           input logic zero,
                                                           input logic [RES_W-1:0] q);
    logic [COORD_W-1:0] v;
    if (zero) begin
      v = '0;
    end else if (!neg) begin
      v = (sat || q[RES_W-1]) ? 16'h7FFF : q;
    end else begin
      v = (sat || q > 16'h8000) ? 16'h8000 : (~q + 16'd1);
    end
    return signed'(v);
  endfunction

endpackage

// ===== rtl/transverse_spherocity_scan_top.sv =====
// ----------------------------------------------------------------------------
// transverse_spherocity_scan_top: per-class transverse spherocity, angle scan
// Flow: load N particles, take the class sums (two unit-vector divides per
//   particle with en_unit_r set), scan 360 axes, then send 4 result words.
// No new event is taken until the last result word is accepted; the scan
//   shares one 33x33 multiplier and 16-step restoring divider, one sequencer.
// Reset: rst_n synchronous, active low; clears count, overflow, minima, state.
//   The particle store is not cleared; only entries written this event are read.
// ----------------------------------------------------------------------------
module transverse_spherocity_scan_top
  import tss_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_mom_x,
  input  logic signed [COORD_W-1:0] in_mom_y,
  input  logic [PT_W-1:0]           in_mom_t,
  input  logic [MASK_W-1:0]         in_class_mask,
  input  logic                      in_last_particle,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [CLASS_W-1:0]        out_class_index,
  output logic [RES_W-1:0]          out_spher_pt,
  output logic [RES_W-1:0]          out_spher_unit,
  output logic                      out_class_empty,
  output logic                      out_store_overflow,
  output logic                      out_last_result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [0:0]                cfg_index,
  input  logic                      cfg_data
);

  typedef enum logic [12:0] {
    ST_IDLE     = 13'b0000000000001,
    ST_PREP_RD  = 13'b0000000000010,
    ST_PREP_SUM = 13'b0000000000100,
    ST_PREP_DX  = 13'b0000000001000,
    ST_PREP_DY  = 13'b0000000010000,
    ST_ANG      = 13'b0000000100000,
    ST_SC_RD    = 13'b0000001000000,
    ST_SC_MUL   = 13'b0000010000000,
    ST_RT_LOAD  = 13'b0000100000000,
    ST_RT_DIV   = 13'b0001000000000,
    ST_RT_CMP   = 13'b0010000000000,
    ST_OUT_MUL  = 13'b0100000000000,
    ST_EMIT     = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic en_pt_r, en_unit_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [ANG_W-1:0]  ang_r, ang_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SEL_W-1:0]  sel_r, sel_nxt;
  logic [CLASS_W-1:0] cls_r, cls_nxt;

  logic [DEN_W-1:0] den0_r [CLASSES];
  logic [DEN_W-1:0] den0_nxt [CLASSES];
  logic [CNT_W-1:0] cnt_r [CLASSES];
  logic [CNT_W-1:0] cnt_nxt [CLASSES];
  logic [NUM_W-1:0] acc0_r [CLASSES];
  logic [NUM_W-1:0] acc0_nxt [CLASSES];
  logic [NUM_W-1:0] acc1_r [CLASSES];
  logic [NUM_W-1:0] acc1_nxt [CLASSES];
  logic [SQ_W-1:0]  best_r [NKIND*CLASSES];
  logic [SQ_W-1:0]  best_nxt [NKIND*CLASSES];

  logic signed [COORD_W-1:0] ux_r, ux_nxt;
  logic signed [CROSS_W-1:0] pa_r, pa_nxt;
  logic [RES_W-1:0] res_pt_r, res_pt_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [CLASS_W-1:0]   out_class_r, out_class_nxt;
  logic [RES_W-1:0]     out_pt_r, out_pt_nxt;
  logic [RES_W-1:0]     out_unit_r, out_unit_nxt;
  logic                 out_empty_r, out_empty_nxt;
  logic                 out_ovf_r, out_ovf_nxt;
  logic                 out_last_r, out_last_nxt;

  // particle and unit-vector memories
  particle_t part_mem [MAX_PARTICLES];
  unit_vec_t unit_mem [MAX_PARTICLES];
  particle_t rd_part_r;
  unit_vec_t rd_unit_r;
  logic      um_we;
  unit_vec_t um_wdata;

  // axis table read
  logic signed [COORD_W-1:0] nx_r, ny_r;

  // shared multiplier
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_r;

  // shared divider
  logic             div_load;
  logic [NUM_W-1:0] div_num_in;
  logic [DEN_W-1:0] div_den_in;
  logic [NUM_W-1:0] div_rem_r;
  logic [NUM_W-1:0] div_dsh_r;
  logic [RES_W-1:0] div_q_r;
  logic [DBIT_W-1:0] div_bit_r;
  logic             div_run_r, div_sat_r, div_zero_r;
  logic [RES_W-1:0] ratio_q;

  logic in_acc, out_acc, last_idx;
  logic signed [CROSS_W-1:0] cross_d;
  logic [NUM_W-1:0]  cross_abs;
  logic [RES_W-1:0]  scaled;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid_r && out_ready;
  assign last_idx  = ({1'b0, idx_r} == count_r - CNT_W'(1));

  assign out_valid          = out_valid_r;
  assign out_class_index    = out_class_r;
  assign out_spher_pt       = out_pt_r;
  assign out_spher_unit     = out_unit_r;
  assign out_class_empty    = out_empty_r;
  assign out_store_overflow = out_ovf_r;
  assign out_last_result    = out_last_r;

  // cross term and scale of the registered product
  assign cross_d   = pa_r - $signed(prod_r[CROSS_W-1:0]);
  assign cross_abs = NUM_W'(unsigned'(cross_d[CROSS_W-1] ? -cross_d : cross_d));
  assign scaled    = (|prod_r[PROD_W-1:SCALE_SHIFT+RES_W]) ? '1
                                                             : prod_r[SCALE_SHIFT +: RES_W];
  assign ratio_q   = div_zero_r ? '0 : (div_sat_r ? '1 : div_q_r);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_pt_r   <= 1'b1;
      en_unit_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_EN_PT:   en_pt_r   <= cfg_data;
        REG_EN_UNIT: en_unit_r <= cfg_data;
      endcase
    end
  end

  // store writes and registered reads
  always_ff @(posedge clk) begin
    if (in_acc && count_r < CNT_W'(MAX_PARTICLES)) begin
      part_mem[count_r[ADDR_W-1:0]] <= '{x: in_mom_x, y: in_mom_y, t: in_mom_t,
                                         mask: in_class_mask};
    end
    rd_part_r <= part_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (um_we) begin
      unit_mem[idx_r] <= um_wdata;
    end
    rd_unit_r <= unit_mem[idx_r];
  end

  // axis table lookup
  always_ff @(posedge clk) begin
    nx_r <= COS_TAB[ang_r];
    ny_r <= SIN_TAB[ang_r];
  end

  // multiplier with registered product
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_run_r <= 1'b0;
    end else if (div_load) begin
      div_rem_r  <= div_num_in;
      div_dsh_r  <= NUM_W'(div_den_in) << (RES_W - 1);
      div_q_r    <= '0;
      div_bit_r  <= DBIT_W'(RES_W - 1);
      div_run_r  <= 1'b1;
      div_sat_r  <= (div_num_in[NUM_W-1:RES_W] >= div_den_in);
      div_zero_r <= (div_den_in == '0);
    end else if (div_run_r) begin
      if (div_rem_r >= div_dsh_r) begin
        div_rem_r <= div_rem_r - div_dsh_r;
      end
      div_q_r   <= {div_q_r[RES_W-2:0], (div_rem_r >= div_dsh_r)};
      div_dsh_r <= div_dsh_r >> 1;
      if (div_bit_r == '0) begin
        div_run_r <= 1'b0;
      end else begin
        div_bit_r <= div_bit_r - 1'b1;
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    idx_nxt   = idx_r;
    ang_nxt   = ang_r;
    step_nxt  = step_r;
    sel_nxt   = sel_r;
    cls_nxt   = cls_r;
    den0_nxt  = den0_r;
    cnt_nxt   = cnt_r;
    acc0_nxt  = acc0_r;
    acc1_nxt  = acc1_r;
    best_nxt  = best_r;
    ux_nxt    = ux_r;
    pa_nxt    = pa_r;
    res_pt_nxt    = res_pt_r;
    out_valid_nxt = out_valid_r;
    out_class_nxt = out_class_r;
    out_pt_nxt    = out_pt_r;
    out_unit_nxt  = out_unit_r;
    out_empty_nxt = out_empty_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;
    mul_a      = '0;
    mul_b      = '0;
    div_load   = 1'b0;
    div_num_in = '0;
    div_den_in = '0;
    um_we      = 1'b0;
    um_wdata   = '{ux: ux_r,
                   uy: unit_clamp(rd_part_r.y[COORD_W-1], div_sat_r, div_zero_r, div_q_r)};

    unique case (state_r)
      // take words, store while room remains
      ST_IDLE: begin
        if (in_acc) begin
          if (count_r < CNT_W'(MAX_PARTICLES)) begin
            count_nxt = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_particle) begin
            idx_nxt = '0;
            for (int c = 0; c < CLASSES; c++) begin
              den0_nxt[c] = '0;
              cnt_nxt[c]  = '0;
            end
            for (int j = 0; j < NKIND*CLASSES; j++) begin
              best_nxt[j] = '1;
            end
            state_nxt = ST_PREP_RD;
          end
        end
      end

      ST_PREP_RD: begin
        state_nxt = ST_PREP_SUM;
      end

      // class sums, then unit vector when enabled
      ST_PREP_SUM: begin
        for (int c = 0; c < CLASSES; c++) begin
          if (rd_part_r.mask[c]) begin
            den0_nxt[c] = den0_r[c] + DEN_W'(rd_part_r.t);
            cnt_nxt[c]  = cnt_r[c] + 1'b1;
          end
        end
        if (en_unit_r) begin
          div_load   = 1'b1;
          div_num_in = unit_num(rd_part_r.x);
          div_den_in = DEN_W'(rd_part_r.t);
          state_nxt  = ST_PREP_DX;
        end else if (last_idx) begin
          idx_nxt   = '0;
          ang_nxt   = '0;
          state_nxt = ST_ANG;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_PREP_RD;
        end
      end

      ST_PREP_DX: begin
        if (!div_run_r) begin
          ux_nxt     = unit_clamp(rd_part_r.x[COORD_W-1], div_sat_r, div_zero_r, div_q_r);
          div_load   = 1'b1;
          div_num_in = unit_num(rd_part_r.y);
          div_den_in = DEN_W'(rd_part_r.t);
          state_nxt  = ST_PREP_DY;
        end
      end

      ST_PREP_DY: begin
        if (!div_run_r) begin
          um_we = 1'b1;
          if (last_idx) begin
            idx_nxt   = '0;
            ang_nxt   = '0;
            state_nxt = ST_ANG;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_PREP_RD;
          end
        end
      end

      // new axis: clear sums, wait for table and first particle
      ST_ANG: begin
        for (int c = 0; c < CLASSES; c++) begin
          acc0_nxt[c] = '0;
          acc1_nxt[c] = '0;
        end
        step_nxt  = '0;
        state_nxt = ST_SC_MUL;
      end

      ST_SC_RD: begin
        step_nxt  = '0;
        state_nxt = ST_SC_MUL;
      end

      // two cross products per particle through the one multiplier
      ST_SC_MUL: begin
        step_nxt = step_r + 1'b1;
        unique case (step_r)
          3'd0: begin
            mul_a = MUL_W'(ny_r);
            mul_b = MUL_W'(rd_part_r.x);
          end
          3'd1: begin
            pa_nxt = prod_r[CROSS_W-1:0];
            mul_a  = MUL_W'(nx_r);
            mul_b  = MUL_W'(rd_part_r.y);
          end
          3'd2: begin
            if (en_pt_r) begin
              for (int c = 0; c < CLASSES; c++) begin
                if (rd_part_r.mask[c]) acc0_nxt[c] = acc0_r[c] + cross_abs;
              end
            end
            mul_a = MUL_W'(ny_r);
            mul_b = MUL_W'(rd_unit_r.ux);
          end
          3'd3: begin
            pa_nxt = prod_r[CROSS_W-1:0];
            mul_a  = MUL_W'(nx_r);
            mul_b  = MUL_W'(rd_unit_r.uy);
          end
          default: begin
            if (en_unit_r) begin
              for (int c = 0; c < CLASSES; c++) begin
                if (rd_part_r.mask[c]) acc1_nxt[c] = acc1_r[c] + cross_abs;
              end
            end
            if (last_idx) begin
              sel_nxt   = '0;
              state_nxt = ST_RT_LOAD;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = ST_SC_RD;
            end
          end
        endcase
      end

      // ratio of this axis for one kind and class
      ST_RT_LOAD: begin
        div_load = 1'b1;
        if (sel_r[SEL_W-1]) begin
          div_num_in = acc1_r[sel_r[CLASS_W-1:0]];
          div_den_in = DEN_W'(cnt_r[sel_r[CLASS_W-1:0]]) << CNT_SHIFT;
        end else begin
          div_num_in = acc0_r[sel_r[CLASS_W-1:0]] << 1;
          div_den_in = den0_r[sel_r[CLASS_W-1:0]];
        end
        state_nxt = ST_RT_DIV;
      end

      ST_RT_DIV: begin
        mul_a = MUL_W'(ratio_q);
        mul_b = MUL_W'(ratio_q);
        if (!div_run_r) begin
          state_nxt = ST_RT_CMP;
        end
      end

      // keep the minimum squared ratio, then next kind and class, next axis or output
      ST_RT_CMP: begin
        if (prod_r[SQ_W-1:0] < best_r[sel_r]) begin
          best_nxt[sel_r] = prod_r[SQ_W-1:0];
        end
        if (sel_r == SEL_W'(NKIND*CLASSES - 1)) begin
          if (ang_r == ANG_W'(ANGLE_STEPS - 1)) begin
            cls_nxt   = '0;
            step_nxt  = '0;
            state_nxt = ST_OUT_MUL;
          end else begin
            ang_nxt   = ang_r + 1'b1;
            idx_nxt   = '0;
            state_nxt = ST_ANG;
          end
        end else begin
          sel_nxt   = sel_r + 1'b1;
          state_nxt = ST_RT_LOAD;
        end
      end

      // scale both minima by pi^2/4 and load the result word
      ST_OUT_MUL: begin
        step_nxt = step_r + 1'b1;
        unique case (step_r)
          3'd0: begin
            mul_a = MUL_W'(best_r[{1'b0, cls_r}]);
            mul_b = signed'(QUARTER_PI_SQ);
          end
          3'd1: begin
            res_pt_nxt = scaled;
            mul_a = MUL_W'(best_r[{1'b1, cls_r}]);
            mul_b = signed'(QUARTER_PI_SQ);
          end
          default: begin
            out_valid_nxt = 1'b1;
            out_class_nxt = cls_r;
            out_empty_nxt = (cnt_r[cls_r] == '0);
            out_pt_nxt    = (en_pt_r && cnt_r[cls_r] != '0) ? res_pt_r : '0;
            out_unit_nxt  = (en_unit_r && cnt_r[cls_r] != '0) ? scaled : '0;
            out_ovf_nxt   = ovf_r;
            out_last_nxt  = (cls_r == CLASS_W'(CLASSES - 1));
            state_nxt     = ST_EMIT;
          end
        endcase
      end

      // hold the word until taken; drop event state after the last class
      ST_EMIT: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          if (cls_r == CLASS_W'(CLASSES - 1)) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            for (int j = 0; j < NKIND*CLASSES; j++) begin
              best_nxt[j] = '1;
            end
            state_nxt = ST_IDLE;
          end else begin
            cls_nxt   = cls_r + 1'b1;
            step_nxt  = '0;
            state_nxt = ST_OUT_MUL;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      ang_r       <= '0;
      step_r      <= '0;
      sel_r       <= '0;
      cls_r       <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < NKIND*CLASSES; j++) begin
        best_r[j] <= '1;
      end
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      idx_r       <= idx_nxt;
      ang_r       <= ang_nxt;
      step_r      <= step_nxt;
      sel_r       <= sel_nxt;
      cls_r       <= cls_nxt;
      out_valid_r <= out_valid_nxt;
      best_r      <= best_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    den0_r      <= den0_nxt;
    cnt_r       <= cnt_nxt;
    acc0_r      <= acc0_nxt;
    acc1_r      <= acc1_nxt;
    ux_r        <= ux_nxt;
    pa_r        <= pa_nxt;
    res_pt_r    <= res_pt_nxt;
    out_class_r <= out_class_nxt;
    out_pt_r    <= out_pt_nxt;
    out_unit_r  <= out_unit_nxt;
    out_empty_r <= out_empty_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

// ===== rtl/tss_checker.sv =====
// ----------------------------------------------------------------------------
// tss_checker: port-level checks for the spherocity scan
// Watches the top level's ports and flags ordering and result slips.
// ----------------------------------------------------------------------------
module tss_checker
  import tss_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_last_particle,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [CLASS_W-1:0]        out_class_index,
  input logic [RES_W-1:0]          out_spher_pt,
  input logic [RES_W-1:0]          out_spher_unit,
  input logic                      out_class_empty,
  input logic                      out_store_overflow,
  input logic                      out_last_result
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_class_index)
                                && $stable(out_spher_pt) && $stable(out_spher_unit)
                                && $stable(out_class_empty) && $stable(out_store_overflow)
                                && $stable(out_last_result))
    else $error("result word changed while stalled");

  // no new particle while results are pending
  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input open while a result is pending");

  // the last particle closes the input
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_particle |=> !in_ready)
    else $error("input still open after last particle");

  // after the final class result the block is idle again
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_result |=> in_ready && !out_valid)
    else $error("not idle after final result");

  // an empty class reports zero spherocity
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_class_empty |-> out_spher_pt == '0 && out_spher_unit == '0)
    else $error("empty class with nonzero result");

endmodule

bind transverse_spherocity_scan_top tss_checker u_tss_checker (.*);
